// ===== rtl/core/rkp_pkg.sv =====
package rkp_pkg;

	localparam int FACTOR_BITS = 16;
	localparam int WORD_BITS = 2 * FACTOR_BITS;
	localparam logic [5:0] EXP_FIRST = 6'd3;
	localparam logic [5:0] EXP_LAST = 6'd63;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_N,
		ST_MUL_PHI,
		ST_GCD_LOOP,
		ST_GCD_DIV,
		ST_GCD_POST,
		ST_INV_EDIV,
		ST_INV_EPOST,
		ST_INV_LOOP,
		ST_INV_DIV,
		ST_INV_MUL,
		ST_INV_UPD,
		ST_FIX
	} rkp_state_t;

endpackage

// ===== rtl/core/rsa_key_from_primes_top.sv =====
// RSA key builder: start with busy low takes prime_p and prime_q; done pulses for one
// cycle with modulus, public_exponent, private_exponent and bad_input, which must be
// taken in that cycle since the receiver cannot stall. busy stays high for the whole
// run and is already low in the done cycle. Each division goes through one shared
// restoring divider at one quotient bit a cycle; the gcd search over odd e runs Euclid
// divisions for each candidate, and each extended Euclid step runs a loop state,
// one division, a multiply state and an update state. A factor below two never
// raises busy: its zero word with bad_input comes out in the cycle after it is taken.
module rsa_key_from_primes_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [rkp_pkg::FACTOR_BITS-1:0]        prime_p,
	input  logic [rkp_pkg::FACTOR_BITS-1:0]        prime_q,
	output logic                                   busy,
	output logic                                   done,
	output logic [rkp_pkg::WORD_BITS-1:0]          modulus,
	output logic [5:0]                             public_exponent,
	output logic [rkp_pkg::WORD_BITS-1:0]          private_exponent,
	output logic                                   bad_input
);
	import rkp_pkg::*;

	localparam int CNT_BITS = $clog2(WORD_BITS);

	rkp_state_t state_q, state_d;

	logic [FACTOR_BITS-1:0] p_q, fq_q;
	logic [WORD_BITS-1:0] phi_q, a_q, b_q, prod_q;
	logic [5:0] e_q;
	logic signed [WORD_BITS:0] s0_q, s1_q;

	logic [WORD_BITS:0] div_rem_q;
	logic [WORD_BITS-1:0] div_quo_q, div_den_q;
	logic [CNT_BITS-1:0] div_cnt_q;

	logic [WORD_BITS-1:0] mod_q, d_q;
	logic [5:0] res_e_q;
	logic bad_q, done_q;

	logic accept, div_last;
	logic [WORD_BITS:0] rem_sh, rem_nx;
	logic rem_ge;
	logic [WORD_BITS-1:0] mul_a, mul_b, s1_mag;
	logic [2*WORD_BITS-1:0] mul_full;
	logic signed [WORD_BITS:0] s_next;
	logic [WORD_BITS:0] d_fix;

	assign accept = start && (state_q == ST_IDLE);
	assign div_last = (div_cnt_q == CNT_BITS'(WORD_BITS - 1));

	// restoring divider step
	assign rem_sh = {div_rem_q[WORD_BITS-1:0], div_quo_q[WORD_BITS-1]};
	assign rem_ge = (rem_sh >= {1'b0, div_den_q});
	assign rem_nx = rem_ge ? (rem_sh - {1'b0, div_den_q}) : rem_sh;

	assign s1_mag = s1_q[WORD_BITS] ? WORD_BITS'(-s1_q) : s1_q[WORD_BITS-1:0];

	always_comb begin
		case (state_q)
			ST_MUL_N: begin
				mul_a = {{FACTOR_BITS{1'b0}}, p_q};
				mul_b = {{FACTOR_BITS{1'b0}}, fq_q};
			end
			ST_MUL_PHI: begin
				mul_a = {{FACTOR_BITS{1'b0}}, p_q - 1'b1};
				mul_b = {{FACTOR_BITS{1'b0}}, fq_q - 1'b1};
			end
			default: begin
				mul_a = div_quo_q;
				mul_b = s1_mag;
			end
		endcase
	end
	assign mul_full = mul_a * mul_b;

	// Bezout coefficients stay within +-phi, so signed add/sub is exact
	assign s_next = s1_q[WORD_BITS] ? (s0_q + $signed({1'b0, prod_q}))
	                                : (s0_q - $signed({1'b0, prod_q}));
	assign d_fix = s0_q[WORD_BITS] ? (s0_q + {1'b0, phi_q}) : s0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (prime_p < 2 || prime_q < 2) state_d = ST_IDLE;
					else state_d = ST_MUL_N;
				end
			end
			ST_MUL_N:    state_d = ST_MUL_PHI;
			ST_MUL_PHI:  state_d = ST_GCD_LOOP;
			ST_GCD_LOOP: begin
				if (b_q != '0) state_d = ST_GCD_DIV;
				else if (a_q == WORD_BITS'(1)) state_d = ST_INV_EDIV;
				else if (e_q == EXP_LAST) state_d = ST_IDLE;
			end
			ST_GCD_DIV:   if (div_last) state_d = ST_GCD_POST;
			ST_GCD_POST:  state_d = ST_GCD_LOOP;
			ST_INV_EDIV:  if (div_last) state_d = ST_INV_EPOST;
			ST_INV_EPOST: state_d = ST_INV_LOOP;
			ST_INV_LOOP:  state_d = (b_q == '0) ? ST_FIX : ST_INV_DIV;
			ST_INV_DIV:   if (div_last) state_d = ST_INV_MUL;
			ST_INV_MUL:   state_d = ST_INV_UPD;
			ST_INV_UPD:   state_d = ST_INV_LOOP;
			ST_FIX:       state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			div_cnt_q <= '0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (prime_p < 2 || prime_q < 2)) done_q <= 1'b1;
				end
				ST_GCD_LOOP: begin
					if (b_q == '0 && a_q != WORD_BITS'(1) && e_q == EXP_LAST) done_q <= 1'b1;
				end
				ST_GCD_DIV, ST_INV_EDIV, ST_INV_DIV: div_cnt_q <= div_cnt_q + 1'b1;
				ST_FIX: done_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					p_q <= prime_p;
					fq_q <= prime_q;
					mod_q <= '0;
					res_e_q <= '0;
					d_q <= '0;
					bad_q <= (prime_p < 2 || prime_q < 2);
				end
			end
			ST_MUL_N: begin
				mod_q <= mul_full[WORD_BITS-1:0];
				e_q <= EXP_FIRST;
			end
			ST_MUL_PHI: begin
				phi_q <= mul_full[WORD_BITS-1:0];
				b_q <= mul_full[WORD_BITS-1:0];
				a_q <= WORD_BITS'(EXP_FIRST);
			end
			ST_GCD_LOOP: begin
				if (b_q != '0) begin
					div_rem_q <= '0;
					div_quo_q <= a_q;
					div_den_q <= b_q;
				end else if (a_q == WORD_BITS'(1)) begin
					div_rem_q <= '0;
					div_quo_q <= WORD_BITS'(e_q);
					div_den_q <= phi_q;
				end else if (e_q == EXP_LAST) begin
					res_e_q <= '0;
					d_q <= '0;
				end else begin
					e_q <= e_q + 6'd2;
					a_q <= WORD_BITS'(e_q + 6'd2);
					b_q <= phi_q;
				end
			end
			ST_GCD_DIV, ST_INV_EDIV, ST_INV_DIV: begin
				div_rem_q <= rem_nx;
				div_quo_q <= {div_quo_q[WORD_BITS-2:0], rem_ge};
			end
			ST_GCD_POST: begin
				a_q <= b_q;
				b_q <= div_rem_q[WORD_BITS-1:0];
			end
			ST_INV_EPOST: begin
				a_q <= phi_q;
				b_q <= div_rem_q[WORD_BITS-1:0];
				s0_q <= '0;
				s1_q <= (WORD_BITS+1)'(1);
			end
			ST_INV_LOOP: begin
				div_rem_q <= '0;
				div_quo_q <= a_q;
				div_den_q <= b_q;
			end
			ST_INV_MUL: begin
				prod_q <= mul_full[WORD_BITS-1:0];
				a_q <= b_q;
				b_q <= div_rem_q[WORD_BITS-1:0];
			end
			ST_INV_UPD: begin
				s0_q <= s1_q;
				s1_q <= s_next;
			end
			ST_FIX: begin
				res_e_q <= e_q;
				d_q <= d_fix[WORD_BITS-1:0];
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign modulus = mod_q;
	assign public_exponent = res_e_q;
	assign private_exponent = d_q;
	assign bad_input = bad_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result word while busy");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && bad_input |-> modulus == '0 && public_exponent == '0 && private_exponent == '0)
		else $error("bad input word with nonzero results");
	a_e_odd: assert property (@(posedge clk) disable iff (!arst_n)
		done && public_exponent != '0 |-> public_exponent[0])
		else $error("even public exponent");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && prime_p >= 2 && prime_q >= 2 |=> busy)
		else $error("accepted word did not raise busy");
`endif

endmodule

// ===== dv/rsa_key_from_primes_top_tb.sv =====
module rsa_key_from_primes_top_tb;
	import rkp_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;

	typedef struct {
		logic [WORD_BITS-1:0] modulus;
		logic [5:0]           public_exponent;
		logic [WORD_BITS-1:0] private_exponent;
		logic                 bad_input;
	} key_word_t;

	class key_scoreboard;
		key_word_t keys_due[$];
		int        errors = 0;

		function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
			longint unsigned r;
			while (b != 0) begin
				r = a % b;
				a = b;
				b = r;
			end
			return a;
		endfunction

		// extended Euclid, coefficient kept in [0, m)
		function automatic longint unsigned inverse_of(longint unsigned e, longint unsigned m);
			longint unsigned r0, r1, s0, s1, qt, rn, prod, sn;
			r0 = m;
			r1 = e % m;
			s0 = 0;
			s1 = 1 % m;
			while (r1 != 0) begin
				qt = r0 / r1;
				rn = r0 - qt * r1;
				prod = ((qt % m) * s1) % m;
				sn = (s0 >= prod) ? s0 - prod : s0 + (m - prod);
				r0 = r1; r1 = rn;
				s0 = s1; s1 = sn;
			end
			return s0;
		endfunction

		function automatic key_word_t build_key(logic [FACTOR_BITS-1:0] p,
				logic [FACTOR_BITS-1:0] q);
			key_word_t k;
			longint unsigned n, phi, e;
			bit found;
			k = '{default: '0};
			if (p < 2 || q < 2) begin
				k.bad_input = 1'b1;
				return k;
			end
			n = longint'(p) * longint'(q);
			phi = longint'(p - 1) * longint'(q - 1);
			found = 0;
			for (e = EXP_FIRST; e <= EXP_LAST; e += 2) begin
				if (gcd64(e, phi) == 1) begin
					found = 1;
					break;
				end
			end
			k.modulus = n[WORD_BITS-1:0];
			if (found) begin
				k.public_exponent = e[5:0];
				k.private_exponent = WORD_BITS'(inverse_of(e, phi));
			end
			return k;
		endfunction

		function void note_word(logic [FACTOR_BITS-1:0] p, logic [FACTOR_BITS-1:0] q);
			keys_due.push_back(build_key(p, q));
		endfunction

		function void check_word(key_word_t got);
			key_word_t exp_k;
			if (keys_due.size() == 0) begin
				$error("result word with nothing pending");
				errors++;
				return;
			end
			exp_k = keys_due.pop_front();
			if (got.modulus !== exp_k.modulus) begin
				$error("modulus: expected %0h, got %0h", exp_k.modulus, got.modulus);
				errors++;
			end
			if (got.public_exponent !== exp_k.public_exponent) begin
				$error("public_exponent: expected %0d, got %0d",
					exp_k.public_exponent, got.public_exponent);
				errors++;
			end
			if (got.private_exponent !== exp_k.private_exponent) begin
				$error("private_exponent: expected %0h, got %0h",
					exp_k.private_exponent, got.private_exponent);
				errors++;
			end
			if (got.bad_input !== exp_k.bad_input) begin
				$error("bad_input: expected %0b, got %0b", exp_k.bad_input, got.bad_input);
				errors++;
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic [FACTOR_BITS-1:0] prime_p = '0;
	logic [FACTOR_BITS-1:0] prime_q = '0;
	logic                   busy;
	logic                   done;
	logic [WORD_BITS-1:0]   modulus;
	logic [5:0]             public_exponent;
	logic [WORD_BITS-1:0]   private_exponent;
	logic                   bad_input;

	key_scoreboard sb = new();
	int            words_taken = 0;
	int            cycles = 0;

	rsa_key_from_primes_top u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.prime_p          (prime_p),
		.prime_q          (prime_q),
		.busy             (busy),
		.done             (done),
		.modulus          (modulus),
		.public_exponent  (public_exponent),
		.private_exponent (private_exponent),
		.bad_input        (bad_input)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** rsa_key_from_primes_top: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sb.note_word(prime_p, prime_q);
				words_taken++;
			end
			if (done)
				sb.check_word('{modulus, public_exponent, private_exponent, bad_input});
		end
	end

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0)
			n = 0;
		repeat (n) @(negedge clk);
	endtask

	// inputs move on the falling edge; the monitor counts the word on the rising one
	task automatic send_key(logic [FACTOR_BITS-1:0] p, logic [FACTOR_BITS-1:0] q);
		int seen;
		seen = words_taken;
		start = 1'b1;
		prime_p = p;
		prime_q = q;
		do
			@(negedge clk);
		while (words_taken == seen);
		start = 1'b0;
		prime_p = FACTOR_BITS'($urandom);
		prime_q = FACTOR_BITS'($urandom);
		idle_gap();
	endtask

	function automatic logic [FACTOR_BITS-1:0] rand_factor();
		case ($urandom_range(0, 9))
			0:       return FACTOR_BITS'($urandom_range(0, 1));
			1, 2, 3: return FACTOR_BITS'($urandom_range(2, 300));
			default: return FACTOR_BITS'($urandom);
		endcase
	endfunction

	initial begin
		logic [FACTOR_BITS-1:0] p, q;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_key(16'd0, 16'd0);
		send_key(16'd0, 16'd5);
		send_key(16'd1, 16'hFFFF);
		send_key(16'hFFFF, 16'd1);
		send_key(16'd2, 16'd2);      // phi of one
		send_key(16'd2, 16'd3);
		send_key(16'd3, 16'd3);
		send_key(16'd5, 16'd7);
		send_key(16'd7, 16'd11);
		send_key(16'd211, 16'd2);    // phi divisible by 3, 5, 7
		send_key(16'd30031, 16'd2);  // phi = 30030
		send_key(16'hFFFF, 16'hFFFF);
		send_key(16'd65521, 16'd65519);
		send_key(16'hAAAA, 16'h5555);
		send_key(16'h5555, 16'hAAAA);
		send_key(16'h8000, 16'h7FFF);

		for (int i = 0; i < 124; i++) begin
			p = rand_factor();
			q = rand_factor();
			send_key(p, q);
		end

		while (sb.keys_due.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (sb.errors == 0)
			$display("** rsa_key_from_primes_top: PASSED **");
		else
			$display("** rsa_key_from_primes_top: FAILED **");
		$finish;
	end

endmodule
